FILE: src/qra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qra_pkg
// Shared constants, codes and helpers for the quadtree region allocator.
// ----------------------------------------------------------------------------
package qra_pkg;

    localparam int C_MAX_LEVELS = 6;
    localparam int C_DIM_W      = 16;
    localparam int C_PT_W       = 17;
    localparam int C_LOD_W      = 4;
    localparam int C_STATUS_W   = 2;
    localparam int C_CFG_IDX_W  = 2;

    localparam logic [C_DIM_W-1:0] C_ATLAS_RESET = 16'd1024;

    localparam logic [C_STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [C_STATUS_W-1:0] ST_NOSPACE  = 2'd1;
    localparam logic [C_STATUS_W-1:0] ST_NOTFOUND = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [C_CFG_IDX_W-1:0] CFG_ATLAS_W    = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_ATLAS_H    = 2'd1;
    localparam logic [C_CFG_IDX_W-1:0] CFG_COMPRESSED = 2'd2;

    // node entry: split flag and occupied flag
    typedef struct packed {
        logic split;
        logic occ;
    } t_node;

    // floor(log2(v)), zero for v of 0 or 1
    function automatic logic [C_LOD_W-1:0] f_flog2(input logic [C_DIM_W-1:0] v);
        logic [C_LOD_W-1:0] r;
        r = '0;
        for (int i = 1; i < C_DIM_W; i++) begin
            if (v[i]) begin
                r = C_LOD_W'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: src/qra_node_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qra_node_mem
// Node flag store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module qra_node_mem #(
    parameter int NODES = 5461,
    parameter int AW    = 13
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  qra_pkg::t_node    i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output qra_pkg::t_node    o_rdata
);
    import qra_pkg::*;

    t_node r_mem [NODES];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/quadtree_region_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadtree_region_allocator_top
// Two-dimensional buddy allocator: depth-first quadtree walk over node flags.
//
//   channel | direction | handshake                   | payload
//   in      | input     | i_in_valid / o_in_stall     | command, req size, region
//   out     | output    | o_out_valid / i_out_stall   | status, start, lod_max
//   cfg     | input     | i_cfg_we                    | i_cfg_index, i_cfg_data
//
// One word at a time: a new word is accepted only after the result of the last is loaded.
// Every visited node is read from memory, then evaluated, with a step on to its sibling;
// a split adds four child writes, a climb goes up one level at a time, and each merge
// check reads and evaluates up to four children per level, then steps up.
// After reset the node memory is swept to zero with o_in_stall high. A finished
// result waits in the output register while i_out_stall holds.
// ----------------------------------------------------------------------------
module quadtree_region_allocator_top #(
    parameter int MAX_LEVELS = qra_pkg::C_MAX_LEVELS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic [qra_pkg::C_DIM_W-1:0]       i_req_width,
    input  logic [qra_pkg::C_DIM_W-1:0]       i_req_height,
    input  logic [qra_pkg::C_DIM_W-1:0]       i_region_x,
    input  logic [qra_pkg::C_DIM_W-1:0]       i_region_y,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [qra_pkg::C_STATUS_W-1:0]    o_status,
    output logic [qra_pkg::C_DIM_W-1:0]       o_start_x,
    output logic [qra_pkg::C_DIM_W-1:0]       o_start_y,
    output logic [qra_pkg::C_LOD_W-1:0]       o_lod_max,
    input  logic                              i_cfg_we,
    input  logic [qra_pkg::C_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [qra_pkg::C_DIM_W-1:0]       i_cfg_data
);
    import qra_pkg::*;

    localparam int NODES = ((1 << (2 * (MAX_LEVELS + 1))) - 1) / 3;
    localparam int AW    = $clog2(NODES);
    localparam int LW    = $clog2(MAX_LEVELS + 1);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_RD     = 10'b0000000100,
        S_EVAL   = 10'b0000001000,
        S_KIDS   = 10'b0000010000,
        S_NEXT   = 10'b0000100000,
        S_UP     = 10'b0001000000,
        S_REL_RD = 10'b0010000000,
        S_REL_EV = 10'b0100000000,
        S_FIN    = 10'b1000000000
    } t_state;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr, n_clr;
    logic                 r_cmd, n_cmd;
    logic [C_DIM_W-1:0]   r_rw, n_rw, r_rh, n_rh;
    logic [C_PT_W-1:0]    r_px, n_px, r_py, n_py;
    logic [AW-1:0]        r_node, n_node, r_par, n_par;
    logic [LW-1:0]        r_lvl, n_lvl;
    logic [C_DIM_W-1:0]   r_x, n_x, r_y, n_y;
    logic [1:0]           r_kid, n_kid;
    logic [C_STATUS_W-1:0] r_st, n_st;
    logic [C_DIM_W-1:0]   r_cfg_w, r_cfg_h;
    logic                 r_cfg_comp;
    logic                 r_out_valid, n_out_valid;
    logic [C_STATUS_W-1:0] r_o_status, n_o_status;
    logic [C_DIM_W-1:0]   r_o_x, n_o_x, r_o_y, n_o_y;
    logic [C_LOD_W-1:0]   r_o_lod, n_o_lod;

    logic                 w_we;
    logic [AW-1:0]        w_waddr, w_raddr;
    t_node                w_wdata, w_rdata;

    logic [C_DIM_W-1:0]   w_w, w_h, w_hw, w_hh, w_lw, w_lh;
    logic [C_LOD_W-1:0]   w_la, w_lb;
    logic [AW+1:0]        w_c0, w_kid_node, w_par_kid;
    logic [AW-1:0]        w_nm1;
    logic [C_PT_W-1:0]    w_xe, w_ye;
    logic                 w_at_max, w_outside;

    qra_node_mem #(.NODES(NODES), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_w        = r_cfg_w >> r_lvl;
    assign w_h        = r_cfg_h >> r_lvl;
    assign w_hw       = w_w >> 1;
    assign w_hh       = w_h >> 1;
    assign w_c0       = {r_node, 2'b01};
    assign w_kid_node = {r_node, 2'b00} + (AW+2)'(r_kid) + (AW+2)'(1);
    assign w_par_kid  = {r_par, 2'b00} + (AW+2)'(r_kid) + (AW+2)'(1);
    assign w_nm1      = r_node - AW'(1);
    assign w_xe       = {1'b0, r_x} + {1'b0, w_w};
    assign w_ye       = {1'b0, r_y} + {1'b0, w_h};
    assign w_at_max   = (r_lvl == LW'(MAX_LEVELS));
    assign w_outside  = (r_px < {1'b0, r_x}) || (r_px >= w_xe)
                     || (r_py < {1'b0, r_y}) || (r_py >= w_ye);
    assign w_lw       = r_cfg_comp ? (r_rw >> 2) : r_rw;
    assign w_lh       = r_cfg_comp ? (r_rh >> 2) : r_rh;
    assign w_la       = f_flog2(w_lw);
    assign w_lb       = f_flog2(w_lh);
    assign w_raddr    = (r_state == S_REL_RD) ? w_par_kid[AW-1:0] : r_node;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_start_x   = r_o_x;
    assign o_start_y   = r_o_y;
    assign o_lod_max   = r_o_lod;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cmd       = r_cmd;
        n_rw        = r_rw;
        n_rh        = r_rh;
        n_px        = r_px;
        n_py        = r_py;
        n_node      = r_node;
        n_par       = r_par;
        n_lvl       = r_lvl;
        n_x         = r_x;
        n_y         = r_y;
        n_kid       = r_kid;
        n_st        = r_st;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_status  = r_o_status;
        n_o_x       = r_o_x;
        n_o_y       = r_o_y;
        n_o_lod     = r_o_lod;
        w_we        = 1'b0;
        w_waddr     = r_node;
        w_wdata     = '0;

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_command;
                    n_rw    = i_req_width;
                    n_rh    = i_req_height;
                    n_px    = {1'b0, i_region_x} + {2'b00, i_req_width[C_DIM_W-1:1]};
                    n_py    = {1'b0, i_region_y} + {2'b00, i_req_height[C_DIM_W-1:1]};
                    n_node  = '0;
                    n_lvl   = '0;
                    n_x     = '0;
                    n_y     = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_cmd == CMD_ALLOC) begin
                    if (w_rdata.occ) begin
                        n_state = S_NEXT;
                    end else if (!w_rdata.split) begin
                        if (w_w < r_rw || w_h < r_rh) begin
                            n_state = S_NEXT;
                        end else if (w_at_max || w_hw < r_rw || w_hh < r_rh) begin
                            // take this leaf
                            w_we    = 1'b1;
                            w_wdata = '{split: 1'b0, occ: 1'b1};
                            n_st    = ST_DONE;
                            n_state = S_FIN;
                        end else begin
                            w_we    = 1'b1;
                            w_wdata = '{split: 1'b1, occ: 1'b0};
                            n_kid   = '0;
                            n_state = S_KIDS;
                        end
                    end else begin
                        n_node  = w_c0[AW-1:0];
                        n_lvl   = r_lvl + LW'(1);
                        n_state = S_RD;
                    end
                end else begin
                    if (w_outside) begin
                        n_state = S_NEXT;
                    end else if (!w_rdata.split || w_at_max) begin
                        w_we    = 1'b1;
                        w_wdata = '{split: w_rdata.split, occ: 1'b0};
                        n_state = S_UP;
                    end else begin
                        n_node  = w_c0[AW-1:0];
                        n_lvl   = r_lvl + LW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_KIDS: begin
                w_we    = 1'b1;
                w_waddr = w_kid_node[AW-1:0];
                n_kid   = r_kid + 2'd1;
                if (r_kid == 2'd3) begin
                    n_node  = w_c0[AW-1:0];
                    n_lvl   = r_lvl + LW'(1);
                    n_state = S_RD;
                end
            end
            S_NEXT: begin
                if (r_node == '0) begin
                    n_st    = (r_cmd == CMD_ALLOC) ? ST_NOSPACE : ST_NOTFOUND;
                    n_state = S_FIN;
                end else begin
                    case (w_nm1[1:0])
                        2'd0: begin
                            n_x     = r_x + w_w;
                            n_node  = r_node + AW'(1);
                            n_state = S_RD;
                        end
                        2'd1: begin
                            n_y     = r_y + w_h;
                            n_node  = r_node + AW'(1);
                            n_state = S_RD;
                        end
                        2'd2: begin
                            n_x     = r_x - w_w;
                            n_node  = r_node + AW'(1);
                            n_state = S_RD;
                        end
                        default: begin
                            // last child: climb and advance the parent
                            n_y    = r_y - w_h;
                            n_node = AW'(w_nm1 >> 2);
                            n_lvl  = r_lvl - LW'(1);
                        end
                    endcase
                end
            end
            S_UP: begin
                if (r_node == '0) begin
                    n_st    = ST_DONE;
                    n_state = S_FIN;
                end else begin
                    n_par   = AW'(w_nm1 >> 2);
                    n_kid   = '0;
                    n_state = S_REL_RD;
                end
            end
            S_REL_RD: begin
                n_state = S_REL_EV;
            end
            S_REL_EV: begin
                if (w_rdata.split || w_rdata.occ) begin
                    n_st    = ST_DONE;
                    n_state = S_FIN;
                end else if (r_kid == 2'd3) begin
                    // merge the parent back into one leaf
                    w_we    = 1'b1;
                    w_waddr = r_par;
                    n_node  = r_par;
                    n_state = S_UP;
                end else begin
                    n_kid   = r_kid + 2'd1;
                    n_state = S_REL_RD;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_st;
                    if (r_cmd == CMD_ALLOC && r_st == ST_DONE) begin
                        n_o_x   = r_x;
                        n_o_y   = r_y;
                        n_o_lod = (w_la < w_lb) ? w_la : w_lb;
                    end else begin
                        n_o_x   = '0;
                        n_o_y   = '0;
                        n_o_lod = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_cfg_w     <= C_ATLAS_RESET;
            r_cfg_h     <= C_ATLAS_RESET;
            r_cfg_comp  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ATLAS_W:    r_cfg_w    <= i_cfg_data;
                    CFG_ATLAS_H:    r_cfg_h    <= i_cfg_data;
                    CFG_COMPRESSED: r_cfg_comp <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_rw       <= n_rw;
        r_rh       <= n_rh;
        r_px       <= n_px;
        r_py       <= n_py;
        r_node     <= n_node;
        r_par      <= n_par;
        r_lvl      <= n_lvl;
        r_x        <= n_x;
        r_y        <= n_y;
        r_kid      <= n_kid;
        r_st       <= n_st;
        r_o_status <= n_o_status;
        r_o_x      <= n_o_x;
        r_o_y      <= n_o_y;
        r_o_lod    <= n_o_lod;
    end

endmodule

FILE: verif/quadtree_region_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadtree_region_allocator_top_tb
// Drives allocate and free words into the quadtree allocator under several
// atlas settings and checks every result against a behavioral quadtree kept
// in the testbench, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module quadtree_region_allocator_top_tb;
    import qra_pkg::*;

    localparam int unsigned LEVELS     = C_MAX_LEVELS;
    localparam int unsigned NODE_TOTAL = ((1 << (2 * (LEVELS + 1))) - 1) / 3;
    localparam int unsigned CYCLE_LIMIT = 100_000_000;

    localparam logic [C_CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [C_STATUS_W-1:0] status;
        logic [C_DIM_W-1:0]    sx;
        logic [C_DIM_W-1:0]    sy;
        logic [C_LOD_W-1:0]    lod;
    } t_result;

    typedef struct {
        int unsigned x, y, w, h;
    } t_region;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_command;
    logic [C_DIM_W-1:0]     i_req_width;
    logic [C_DIM_W-1:0]     i_req_height;
    logic [C_DIM_W-1:0]     i_region_x;
    logic [C_DIM_W-1:0]     i_region_y;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [C_STATUS_W-1:0]  o_status;
    logic [C_DIM_W-1:0]     o_start_x;
    logic [C_DIM_W-1:0]     o_start_y;
    logic [C_LOD_W-1:0]     o_lod_max;
    logic                   i_cfg_we;
    logic [C_CFG_IDX_W-1:0] i_cfg_index;
    logic [C_DIM_W-1:0]     i_cfg_data;

    quadtree_region_allocator_top DUT (.*);

    // tree copy and registers
    bit          tree_split [NODE_TOTAL];
    bit          tree_occ   [NODE_TOTAL];
    int unsigned atlas_w, atlas_h;
    bit          compressed;
    int unsigned hit_x, hit_y;

    t_result     pending_results[$];
    t_region     live_regions[$];
    int unsigned errors;
    int unsigned cycles;
    bit          quiet;
    int unsigned stall_left;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("quadtree_region_allocator_top_tb failed");
            $finish;
        end
    end

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12);
        end
        i_out_stall <= (stall_left != 0);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word status=%0d", o_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_status);
                    errors++;
                end
                if (o_start_x !== want.sx) begin
                    $error("start_x expected %0d actual %0d", want.sx, o_start_x);
                    errors++;
                end
                if (o_start_y !== want.sy) begin
                    $error("start_y expected %0d actual %0d", want.sy, o_start_y);
                    errors++;
                end
                if (o_lod_max !== want.lod) begin
                    $error("lod_max expected %0d actual %0d", want.lod, o_lod_max);
                    errors++;
                end
            end
        end
    end

    function automatic int unsigned log2_floor(int unsigned v);
        int unsigned r;
        r = 0;
        while (v > 1) begin
            v >>= 1;
            r++;
        end
        return r;
    endfunction

    function automatic bit take_leaf(int unsigned n, int unsigned lvl, int unsigned x,
                                     int unsigned y, int unsigned w, int unsigned h,
                                     int unsigned rw, int unsigned rh);
        int unsigned hw, hh;
        hw = w >> 1;
        hh = h >> 1;
        if (n >= NODE_TOTAL || tree_occ[n]) return 1'b0;
        if (!tree_split[n]) begin
            if (w < rw || h < rh) return 1'b0;
            if (lvl >= LEVELS || hw < rw || hh < rh) begin
                tree_occ[n] = 1'b1;
                hit_x = x;
                hit_y = y;
                return 1'b1;
            end
            tree_split[n] = 1'b1;
            for (int k = 1; k <= 4; k++) begin
                tree_split[4 * n + k] = 1'b0;
                tree_occ[4 * n + k]   = 1'b0;
            end
        end
        for (int k = 0; k < 4; k++) begin
            if (take_leaf(4 * n + 1 + k, lvl + 1, (k == 1 || k == 2) ? x + hw : x,
                          (k >= 2) ? y + hh : y, hw, hh, rw, rh))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int unsigned find_leaf(int unsigned n, int unsigned lvl,
                                              int unsigned x, int unsigned y,
                                              int unsigned w, int unsigned h,
                                              int unsigned px, int unsigned py);
        int unsigned hw, hh, r;
        hw = w >> 1;
        hh = h >> 1;
        if (n >= NODE_TOTAL) return NODE_TOTAL;
        if (px < x || px >= x + w || py < y || py >= y + h) return NODE_TOTAL;
        if (!tree_split[n] || lvl >= LEVELS) return n;
        for (int k = 0; k < 4; k++) begin
            r = find_leaf(4 * n + 1 + k, lvl + 1, (k == 1 || k == 2) ? x + hw : x,
                          (k >= 2) ? y + hh : y, hw, hh, px, py);
            if (r < NODE_TOTAL) return r;
        end
        return NODE_TOTAL;
    endfunction

    function automatic void release_leaf(int unsigned n);
        int unsigned p;
        bit all_empty;
        tree_occ[n] = 1'b0;
        while (n > 0) begin
            p = (n - 1) >> 2;
            all_empty = 1'b1;
            for (int k = 1; k <= 4; k++) begin
                if (tree_split[4 * p + k] || tree_occ[4 * p + k]) all_empty = 1'b0;
            end
            if (!all_empty) return;
            tree_split[p] = 1'b0;
            tree_occ[p]   = 1'b0;
            n = p;
        end
    endfunction

    function automatic t_result allocate_or_free(logic cmd, int unsigned rw, int unsigned rh,
                                                 int unsigned rx, int unsigned ry);
        t_result res;
        int unsigned leaf, a, b;
        t_region reg_w;
        res = '0;
        if (cmd == CMD_ALLOC) begin
            if (take_leaf(0, 0, 0, 0, atlas_w, atlas_h, rw, rh)) begin
                a = log2_floor(compressed ? rw / 4 : rw);
                b = log2_floor(compressed ? rh / 4 : rh);
                res.status = ST_DONE;
                res.sx  = hit_x[15:0];
                res.sy  = hit_y[15:0];
                res.lod = C_LOD_W'(a < b ? a : b);
                reg_w.x = hit_x & 16'hFFFF;
                reg_w.y = hit_y & 16'hFFFF;
                reg_w.w = rw;
                reg_w.h = rh;
                live_regions.insert(live_regions.size(), reg_w);
            end else begin
                res.status = ST_NOSPACE;
            end
        end else begin
            leaf = find_leaf(0, 0, 0, 0, atlas_w, atlas_h, rx + rw / 2, ry + rh / 2);
            if (leaf < NODE_TOTAL) begin
                release_leaf(leaf);
                res.status = ST_DONE;
            end else begin
                res.status = ST_NOTFOUND;
            end
        end
        return res;
    endfunction

    task automatic hold_input(int unsigned n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_word(logic cmd, int unsigned rw, int unsigned rh,
                             int unsigned rx, int unsigned ry);
        if (!quiet && $urandom_range(0, 4) == 0) hold_input($urandom_range(1, 12));
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_req_width  <= rw[15:0];
        i_req_height <= rh[15:0];
        i_region_x   <= rx[15:0];
        i_region_y   <= ry[15:0];
        forever begin
            @(posedge i_clk);
            if (i_in_valid && !o_in_stall) break;
        end
        pending_results.insert(pending_results.size(),
                               allocate_or_free(cmd, rw[15:0], rh[15:0],
                                                rx[15:0], ry[15:0]));
    endtask

    task automatic drain();
        hold_input(1);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [C_CFG_IDX_W-1:0] idx, int unsigned value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[15:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_ATLAS_W) atlas_w = value & 16'hFFFF;
        else if (idx == CFG_ATLAS_H) atlas_h = value & 16'hFFFF;
        else if (idx == CFG_COMPRESSED) compressed = value[0];
        @(posedge i_clk);
    endtask

    task automatic set_atlas(int unsigned w, int unsigned h, bit comp);
        drain();
        write_reg(CFG_ATLAS_W, w);
        write_reg(CFG_ATLAS_H, h);
        write_reg(CFG_COMPRESSED, comp);
    endtask

    task automatic test_default_atlas();
        send_word(CMD_ALLOC, 1024, 1024, 0, 0);     // whole root leaf
        send_word(CMD_ALLOC, 1, 1, 0, 0);           // tree full
        send_word(CMD_FREE, 1024, 1024, 0, 0);      // free root leaf
        send_word(CMD_FREE, 1024, 1024, 0, 0);      // free of an empty leaf
        send_word(CMD_ALLOC, 0, 0, 0, 0);           // zero size: split to the bottom
        send_word(CMD_ALLOC, 1, 1, 0, 0);
        send_word(CMD_ALLOC, 65535, 65535, 0, 0);
        send_word(CMD_ALLOC, 300, 200, 0, 0);
        send_word(CMD_FREE, 4, 4, 65535, 65535);    // centre outside the atlas
        send_word(CMD_FREE, 0, 0, 0, 0);
        send_word(CMD_FREE, 1, 1, 16, 0);
        send_word(CMD_FREE, 300, 200, 512, 0);
        send_word(CMD_FREE, 65535, 65535, 65535, 65535);
    endtask

    task automatic test_compressed_and_resize();
        set_atlas(1024, 1024, 1);
        send_word(CMD_ALLOC, 64, 64, 0, 0);
        send_word(CMD_ALLOC, 3, 3, 0, 0);
        send_word(CMD_ALLOC, 65535, 4, 0, 0);
        // geometry follows the registers, tree kept
        drain();
        write_reg(CFG_ATLAS_W, 512);
        write_reg(CFG_UNUSED, 16'hFFFF);            // unknown index, ignored
        send_word(CMD_ALLOC, 100, 100, 0, 0);
        send_word(CMD_FREE, 64, 64, 0, 0);
        send_word(CMD_FREE, 3, 3, 0, 0);
    endtask

    task automatic test_pressure();
        drain();
        send_word(CMD_ALLOC, 10, 10, 0, 0);
        drain();
        send_word(CMD_FREE, 10, 10, 0, 0);
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned r, k, span;
        t_region pick;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                span = atlas_w >> $urandom_range(0, 7);
                k    = atlas_h >> $urandom_range(0, 7);
                send_word(CMD_ALLOC, $urandom_range(1, span > 1 ? span : 1),
                          $urandom_range(1, k > 1 ? k : 1), $urandom, $urandom);
            end else if (r < 88 && live_regions.size() != 0) begin
                k = $urandom_range(0, live_regions.size() - 1);
                pick = live_regions[k];
                live_regions.delete(k);
                send_word(CMD_FREE, pick.w, pick.h, pick.x, pick.y);
            end else begin
                send_word(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic test_random_settings();
        set_atlas(65535, 65535, 1);
        random_phase(150);
        set_atlas(1, 1, 0);
        random_phase(60);
        set_atlas(1000, 600, 1);
        random_phase(170);
        set_atlas($urandom_range(1, 65535), $urandom_range(1, 65535), 0);
        random_phase(170);
        set_atlas(1024, 1024, 0);
        random_phase(170);
        quiet = 1'b1;
        random_phase(180);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = CMD_ALLOC;
        i_req_width  = '0;
        i_req_height = '0;
        i_region_x   = '0;
        i_region_y   = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        atlas_w      = C_ATLAS_RESET;
        atlas_h      = C_ATLAS_RESET;
        compressed   = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_atlas();
        test_compressed_and_resize();
        test_pressure();
        test_random_settings();

        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("quadtree_region_allocator_top_tb passed");
        end else begin
            $display("quadtree_region_allocator_top_tb failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/qra_pkg.sv
src/qra_node_mem.sv
src/quadtree_region_allocator_top.sv
verif/quadtree_region_allocator_top_tb.sv
